// ----- rtl/p6lbl_pkg.sv -----
// Package for the packed 6-bit label decoder.
// Holds the payload and state types, code constants and the character tables.
// No dependencies.
`default_nettype none

package p6lbl_pkg;

  localparam int unsigned MaxResults = 8;

  localparam logic [5:0] CODE_MAX     = 6'h2F;
  localparam logic [5:0] CODE_SYMBOL  = 6'h1C;
  localparam logic [5:0] CODE_SPECIAL = 6'h1B;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;

  typedef enum logic [1:0] {
    SET_NORMAL  = 2'd0,
    SET_SYMBOL  = 2'd1,
    SET_SPECIAL = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_label;
  } p6lbl_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       label_done;
    logic       last_result;
  } p6lbl_out_t;

  typedef struct packed {
    logic [3:0] leftover_bits;
    logic [1:0] group_phase;
    logic [1:0] shift_set;
    logic       past_first_group;
  } p6lbl_state_t;

  // Characters produced by one code: n is 0, 1 or 4.
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] ch;
    logic [1:0]      shift_nxt;
  } p6lbl_emit_t;

  // All results caused by one request, in order from entry 0.
  typedef struct packed {
    logic [3:0]                 count;
    logic                       done;
    logic [MaxResults-1:0][7:0] chars;
    logic [MaxResults-1:0]      valids;
  } p6lbl_list_t;

  // A result of zero means the table leaves that code unmapped.
  function automatic logic [7:0] map_normal(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    case (code) inside
      6'd0:            map_normal = 8'h20;
      [6'd1:6'd26]:    map_normal = c + 8'h40;
      [6'd32:6'd41]:   map_normal = c + 8'h10;
      default:         map_normal = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] map_symbol(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    case (code) inside
      6'd0:            map_symbol = 8'h40;
      [6'd1:6'd15]:    map_symbol = c + 8'h20;
      [6'd26:6'd31]:   map_symbol = c + 8'h20;
      [6'd43:6'd47]:   map_symbol = c + 8'h30;
      default:         map_symbol = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] map_special(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    case (code) inside
      [6'd0:6'd26]:    map_special = c + 8'h60;
      [6'd32:6'd41]:   map_special = c + 8'h10;
      default:         map_special = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_digit = {4'h3, nib};
    end else begin
      hex_digit = {4'h0, nib} + 8'h57;
    end
  endfunction

  // Characters of one code no greater than CODE_MAX, and the next shift set.
  function automatic p6lbl_emit_t emit_code(input logic [5:0] code, input logic [1:0] sh);
    p6lbl_emit_t e;
    logic [7:0]  ch;
    logic        as_hex;
    e.n         = 3'd0;
    e.ch        = '0;
    e.shift_nxt = SET_NORMAL;
    ch          = 8'h00;
    as_hex      = 1'b0;
    case (sh)
      SET_NORMAL: begin
        if (code == CODE_SYMBOL) begin
          e.shift_nxt = SET_SYMBOL;
        end else if (code == CODE_SPECIAL) begin
          e.shift_nxt = SET_SPECIAL;
          as_hex      = 1'b1;
        end else begin
          ch     = map_normal(code);
          as_hex = (ch == 8'h00);
        end
      end
      SET_SYMBOL: begin
        ch     = map_symbol(code);
        as_hex = (ch == 8'h00);
      end
      default: begin
        ch     = map_special(code);
        as_hex = (ch == 8'h00);
      end
    endcase
    if (as_hex) begin
      e.n     = 3'd4;
      e.ch[0] = CH_LT;
      e.ch[1] = hex_digit({2'b00, code[5:4]});
      e.ch[2] = hex_digit(code[3:0]);
      e.ch[3] = CH_GT;
    end else if (ch != 8'h00) begin
      e.n     = 3'd1;
      e.ch[0] = ch;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/p6lbl_decode.sv -----
// Combinational decode of one label byte against the current decoder state.
// Produces the ordered result list and the next state. Uses p6lbl_pkg.
`default_nettype none

module p6lbl_decode
  import p6lbl_pkg::*;
(
  input  p6lbl_in_t    req,
  input  logic         label_mode,
  input  p6lbl_state_t state,
  output p6lbl_list_t  list,
  output p6lbl_state_t state_nxt
);

  p6lbl_state_t st;
  p6lbl_emit_t  ea;
  p6lbl_emit_t  eb;
  logic         term;
  logic [5:0]   c1;
  logic [5:0]   c2;
  logic [7:0]   b;
  logic [3:0]   na;
  logic [3:0]   nab;

  assign b = req.byte_in;

  always_comb begin
    st        = req.start_label ? '0 : state;
    ea        = '0;
    eb        = '0;
    term      = 1'b0;
    c1        = 6'd0;
    c2        = 6'd0;
    state_nxt = st;
    if (label_mode) begin
      if (b == 8'h00) begin
        term = 1'b1;
      end else begin
        ea.n     = 3'd1;
        ea.ch[0] = b;
      end
    end else begin
      case (st.group_phase)
        PH_SECOND: begin
          c1 = {st.leftover_bits[1:0], b[7:4]};
          if (c1 > CODE_MAX) begin
            term = 1'b1;
          end else begin
            ea                      = emit_code(c1, st.shift_set);
            state_nxt.shift_set     = ea.shift_nxt;
            state_nxt.leftover_bits = b[3:0];
            state_nxt.group_phase   = PH_THIRD;
          end
        end
        PH_THIRD: begin
          c1 = {st.leftover_bits, b[7:6]};
          c2 = b[5:0];
          if (c1 > CODE_MAX) begin
            term = 1'b1;
          end else begin
            ea = emit_code(c1, st.shift_set);
            if (c2 > CODE_MAX) begin
              term = 1'b1;
            end else begin
              eb                         = emit_code(c2, ea.shift_nxt);
              state_nxt.shift_set        = eb.shift_nxt;
              state_nxt.leftover_bits    = 4'd0;
              state_nxt.group_phase      = PH_FIRST;
              state_nxt.past_first_group = 1'b1;
            end
          end
        end
        default: begin
          // The phase value that is never reached is handled as the first byte.
          c1 = b[7:2];
          if (c1 > CODE_MAX || (c1 == 6'd0 && !st.past_first_group)) begin
            term = 1'b1;
          end else begin
            ea                      = emit_code(c1, st.shift_set);
            state_nxt.shift_set     = ea.shift_nxt;
            state_nxt.leftover_bits = {2'b00, b[1:0]};
            state_nxt.group_phase   = PH_SECOND;
          end
        end
      endcase
    end
    if (term) begin
      state_nxt = '0;
    end
  end

  assign na  = {1'b0, ea.n};
  assign nab = {1'b0, ea.n} + {1'b0, eb.n};

  // Characters of the first code come first, then the second code's, then
  // the end marker when the label terminated.
  always_comb begin
    list.count = nab + {3'b000, term};
    list.done  = term;
    for (int k = 0; k < MaxResults; k++) begin
      list.chars[k]  = 8'h00;
      list.valids[k] = 1'b0;
      if (4'(k) < na) begin
        list.chars[k]  = ea.ch[2'(k)];
        list.valids[k] = 1'b1;
      end else if (4'(k) < nab) begin
        list.chars[k]  = eb.ch[2'(4'(k) - na)];
        list.valids[k] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/p6lbl_res_buf.sv -----
// Result buffer: holds the results of one request and hands them out one per
// cycle on the result channel while out_stall is low. Uses p6lbl_pkg.
`default_nettype none

module p6lbl_res_buf
  import p6lbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  p6lbl_list_t list,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output p6lbl_out_t  out_data
);

  logic [MaxResults-1:0][7:0] chars_r;
  logic [MaxResults-1:0]      valids_r;
  logic                       done_r;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [2:0]                 idx_r, idx_nxt;
  logic                       busy;
  logic                       take;
  logic                       last;

  assign busy = (cnt_r != 4'd0);
  assign take = busy && !out_stall;
  assign last = ({1'b0, idx_r} == (cnt_r - 4'd1));
  // The buffer can take a new list in the cycle its last result leaves.
  assign free = !busy || (take && last);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = list.count;
      idx_nxt = 3'd0;
    end else if (take && last) begin
      cnt_nxt = 4'd0;
    end else if (take) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      idx_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r  <= list.chars;
      valids_r <= list.valids;
      done_r   <= list.done;
    end
  end

  assign out_valid            = busy;
  assign out_data.char_code   = chars_r[idx_r];
  assign out_data.char_valid  = valids_r[idx_r];
  assign out_data.label_done  = done_r;
  assign out_data.last_result = last;

endmodule

`default_nettype wire

// ----- rtl/packed_6bit_label_decoder_unit.sv -----
// Top level of the packed 6-bit label decoder.
// Instantiates p6lbl_decode and p6lbl_res_buf; uses p6lbl_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    p6lbl_in_t  (byte_in, start_label)
//   out_     output     out_valid / out_stall  p6lbl_out_t (char_code ... last_result)
//   cfg_     input      cfg_wr_en              cfg_wr_data (label_mode)
//
// A request is held in the input register, is decoded, and its results
// (zero to eight) leave the result buffer at one per cycle while out_stall is
// low; the result buffer's drain sets the rate.
// Reset is synchronous, active low, and clears the mode, decoder state and
// both valid flags. A stalled result channel holds the buffer, and the input
// register stalls once it holds a byte whose results cannot yet be loaded.
`default_nettype none

module packed_6bit_label_decoder_unit
  import p6lbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  p6lbl_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output p6lbl_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic         label_mode_r;
  logic         in_v_r, in_v_nxt;
  p6lbl_in_t    in_data_r;
  p6lbl_state_t state_r;
  p6lbl_state_t state_nxt;
  p6lbl_list_t  list;
  logic         buf_free;
  logic         move;
  logic         accept;

  p6lbl_decode u_decode (
    .req        (in_data_r),
    .label_mode (label_mode_r),
    .state      (state_r),
    .list       (list),
    .state_nxt  (state_nxt)
  );

  // A request without results only updates the state and never waits.
  assign move     = in_v_r && ((list.count == 4'd0) || buf_free);
  assign in_stall = in_v_r && !move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (move) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_mode_r <= 1'b0;
      in_v_r       <= 1'b0;
      state_r      <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_wr_en) begin
        label_mode_r <= cfg_wr_data;
      end
      if (move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
  end

  p6lbl_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move && (list.count != 4'd0)),
    .list      (list),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/packed_6bit_label_decoder_unit_tb.sv -----
// Self-checking testbench for packed_6bit_label_decoder_unit.
// Predicts every decoded character from its own label decoder and checks each result.
// Depends on rtl/p6lbl_pkg.sv and rtl/packed_6bit_label_decoder_unit.sv.

module packed_6bit_label_decoder_unit_tb;
  import p6lbl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 12;
  localparam int IdleLimit   = 2000;
  localparam logic [7:0] Tilde = 8'h7E;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  p6lbl_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  p6lbl_out_t out_data;
  logic       cfg_wr_en;
  logic       cfg_wr_data;

  packed_6bit_label_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  string normal_chars  = " ABCDEFGHIJKLMNOPQRSTUVWXYZ~~~~~0123456789~~~~~~";
  string symbol_chars  = "@!\"#$%&'()*+,-./~~~~~~~~~~:;<=>?~~~~~~~~~~~[\\]^_";
  string special_chars = "`abcdefghijklmnopqrstuvwxyz~~~~~0123456789~~~~~~";
  string hex_chars     = "0123456789abcdef";

  // Decoder state as the predictor sees it.
  logic [3:0] pk_left;
  phase_t     pk_phase;
  shift_t     pk_set;
  logic       pk_past;
  logic       pk_mode;

  p6lbl_out_t step_chars[$];
  p6lbl_out_t pending_chars[$];
  logic [5:0] code_buf[$];

  int n_req;
  int n_res;
  int n_err;
  int idle_cnt;

  // Sender and receiver pacing.
  int burst_left;
  int burst_max;
  int gap_max;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_decoder();
    pk_left  = 4'd0;
    pk_phase = PH_FIRST;
    pk_set   = SET_NORMAL;
    pk_past  = 1'b0;
  endfunction

  function automatic void push_char(logic [7:0] c);
    p6lbl_out_t r;
    r.char_code   = c;
    r.char_valid  = 1'b1;
    r.label_done  = 1'b0;
    r.last_result = 1'b0;
    step_chars.push_back(r);
  endfunction

  function automatic void push_hex(logic [5:0] code);
    push_char(8'h3C);
    push_char(hex_chars[{2'b00, code[5:4]}]);
    push_char(hex_chars[code[3:0]]);
    push_char(8'h3E);
  endfunction

  // Characters for one code no greater than CODE_MAX; updates the shift set.
  function automatic void decode_code(logic [5:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    case (pk_set)
      SET_NORMAL: begin
        if (code == CODE_SYMBOL) begin
          pk_set = SET_SYMBOL;
          return;
        end
        if (code == CODE_SPECIAL) begin
          pk_set = SET_SPECIAL;
          push_hex(code);
          return;
        end
        ch = normal_chars[code];
      end
      SET_SYMBOL: begin
        ch     = symbol_chars[code];
        pk_set = SET_NORMAL;
      end
      default: begin
        ch     = special_chars[code];
        pk_set = SET_NORMAL;
      end
    endcase
    if (ch == Tilde) begin
      push_hex(code);
    end else begin
      push_char(ch);
    end
  endfunction

  // Closes the characters of one request and queues them as expected results.
  function automatic void close_request(logic done);
    p6lbl_out_t r;
    if (done) begin
      r = '0;
      r.label_done = 1'b1;
      step_chars.push_back(r);
      for (int k = 0; k < step_chars.size(); k++) begin
        r = step_chars[k];
        r.label_done = 1'b1;
        step_chars[k] = r;
      end
      clear_decoder();
    end
    if (step_chars.size() > 0) begin
      r = step_chars[step_chars.size() - 1];
      r.last_result = 1'b1;
      step_chars[step_chars.size() - 1] = r;
    end
    foreach (step_chars[k]) pending_chars.push_back(step_chars[k]);
    step_chars.delete();
  endfunction

  function automatic void predict_label_byte(p6lbl_in_t d);
    logic [7:0] b;
    logic [5:0] code;
    logic       done;
    b    = d.byte_in;
    done = 1'b0;
    if (d.start_label) clear_decoder();
    if (pk_mode) begin
      if (b == 8'h00) begin
        done = 1'b1;
      end else begin
        push_char(b);
      end
    end else begin
      case (pk_phase)
        PH_SECOND: begin
          code = {pk_left[1:0], b[7:4]};
          if (code > CODE_MAX) begin
            done = 1'b1;
          end else begin
            decode_code(code);
            pk_left  = b[3:0];
            pk_phase = PH_THIRD;
          end
        end
        PH_THIRD: begin
          code = {pk_left, b[7:6]};
          if (code > CODE_MAX) begin
            done = 1'b1;
          end else begin
            decode_code(code);
            code = b[5:0];
            if (code > CODE_MAX) begin
              done = 1'b1;
            end else begin
              decode_code(code);
              pk_left  = 4'd0;
              pk_phase = PH_FIRST;
              pk_past  = 1'b1;
            end
          end
        end
        default: begin
          code = b[7:2];
          if (code > CODE_MAX || (code == 6'd0 && !pk_past)) begin
            done = 1'b1;
          end else begin
            decode_code(code);
            pk_left  = {2'b00, b[1:0]};
            pk_phase = PH_SECOND;
          end
        end
      endcase
    end
    close_request(done);
  endfunction

  // Predicts accepted requests, checks accepted results and runs the watchdog.
  always @(posedge clk) begin
    p6lbl_out_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_label_byte(in_data);
        n_req++;
      end
      if (out_valid && !out_stall) begin
        n_res++;
        if (pending_chars.size() == 0) begin
          $error("unexpected result: char_code %h char_valid %b label_done %b last_result %b",
                 out_data.char_code, out_data.char_valid, out_data.label_done,
                 out_data.last_result);
          n_err++;
        end else begin
          e = pending_chars.pop_front();
          if (out_data.char_code !== e.char_code) begin
            $error("char_code: expected %h, actual %h", e.char_code, out_data.char_code);
            n_err++;
          end
          if (out_data.char_valid !== e.char_valid) begin
            $error("char_valid: expected %b, actual %b", e.char_valid, out_data.char_valid);
            n_err++;
          end
          if (out_data.label_done !== e.label_done) begin
            $error("label_done: expected %b, actual %b", e.label_done, out_data.label_done);
            n_err++;
          end
          if (out_data.last_result !== e.last_result) begin
            $error("last_result: expected %b, actual %b", e.last_result, out_data.last_result);
            n_err++;
          end
        end
      end
      if (cfg_wr_en) pk_mode = cfg_wr_data;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= IdleLimit) begin
          $display("watchdog: no handshake for %0d cycles", IdleLimit);
          $display("packed_6bit_label_decoder_unit regression: fail");
          $finish;
        end
      end
    end
  end

  // Result channel back-pressure: off, scattered, or long runs.
  initial begin
    logic stall_on;
    int   run_left;
    stall_on  = 1'b0;
    run_left  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: begin
          if (run_left == 0) begin
            stall_on = !stall_on;
            run_left = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
          end
          run_left--;
          out_stall <= stall_on;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_label_byte(input logic [7:0] b, input logic st);
    p6lbl_in_t d;
    int        gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    d.byte_in     = b;
    d.start_label = st;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Packs code_buf into bytes, most significant bits first; the tail is padded at random.
  task automatic send_code_buf(input logic first_start);
    logic [13:0] acc;
    logic [7:0]  b;
    int          nb;
    logic        st;
    acc = '0;
    nb  = 0;
    st  = first_start;
    foreach (code_buf[i]) begin
      acc = (acc << 6) | {8'h00, code_buf[i]};
      nb += 6;
      if (nb >= 8) begin
        b = 8'(acc >> (nb - 8));
        nb -= 8;
        send_label_byte(b, st);
        st = 1'b0;
      end
    end
    if (nb > 0) begin
      b = 8'(acc << (8 - nb)) | 8'($urandom_range(0, (1 << (8 - nb)) - 1));
      send_label_byte(b, st);
    end
    code_buf.delete();
  endtask

  // Lets every expected result come out, then writes label_mode.
  task automatic write_label_mode(input logic v);
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed_packed();
    burst_max  = 4;
    gap_max    = 2;
    stall_mode = 0;
    // Every character set, escapes, unmapped codes, then a terminator.
    code_buf = '{6'h01, 6'h1A, 6'h20, 6'h29, 6'h1C, 6'h01, 6'h1B, 6'h01, 6'h1E, 6'h2F,
                 6'h3F};
    send_code_buf(1'b1);
    // Code 0 opening a label, and the largest code, each end an empty label.
    send_label_byte(8'h00, 1'b0);
    send_label_byte(8'hFF, 1'b0);
    // A byte holding only the symbol shift, then code 0 past the first group.
    code_buf = '{6'h1C, 6'h00, 6'h00, 6'h00, 6'h00, 6'h30};
    send_code_buf(1'b0);
    code_buf = '{6'h05, 6'h35};
    send_code_buf(1'b0);
    // A new label started in the middle of a group.
    code_buf = '{6'h07, 6'h08};
    send_code_buf(1'b0);
    send_label_byte({6'h09, 2'b11}, 1'b1);
    send_label_byte(8'hFF, 1'b0);
  endtask

  task automatic test_directed_plain();
    write_label_mode(1'b1);
    stall_mode = 1;
    send_label_byte(8'hFF, 1'b0);
    send_label_byte(8'h01, 1'b0);
    send_label_byte(8'h80, 1'b1);
    send_label_byte(8'h00, 1'b0);
  endtask

  task automatic test_random_packed(input int n_bytes);
    int       stop_at;
    int       n_codes;
    int       r;
    logic [5:0] code;
    logic     open_label;
    write_label_mode(1'b0);
    stop_at    = n_req + n_bytes;
    open_label = 1'b0;
    while (n_req < stop_at) begin
      // The first half runs without idling on either side.
      if (n_req < stop_at - n_bytes / 2) begin
        burst_max  = 1000;
        gap_max    = 0;
        stall_mode = 0;
      end else begin
        burst_max  = 8;
        gap_max    = 6;
        stall_mode = 2;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Raw noise between labels.
        repeat ($urandom_range(1, 3)) send_label_byte(8'($urandom_range(0, 255)),
                                                      1'($urandom_range(0, 1)));
      end else begin
        n_codes = $urandom_range(0, 9);
        for (int i = 0; i < n_codes; i++) begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            code = CODE_SYMBOL;
          end else if (r == 1) begin
            code = CODE_SPECIAL;
          end else begin
            code = 6'($urandom_range(0, 47));
          end
          if (i == 0 && code == 6'd0 && $urandom_range(0, 3) != 0) code = 6'h01;
          code_buf.push_back(code);
        end
        // Most labels end on a terminator; the rest are cut short by the next start.
        if ($urandom_range(0, 7) != 0) begin
          code_buf.push_back(6'($urandom_range(48, 63)));
          send_code_buf(open_label || ($urandom_range(0, 3) == 0));
          open_label = 1'b0;
        end else begin
          send_code_buf(open_label || ($urandom_range(0, 3) == 0));
          open_label = 1'b1;
        end
      end
    end
  endtask

  task automatic test_random_plain(input int n_bytes);
    logic [7:0] b;
    write_label_mode(1'b1);
    burst_max  = 5;
    gap_max    = 4;
    stall_mode = 1;
    repeat (n_bytes) begin
      b = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      send_label_byte(b, ($urandom_range(0, 3) == 0));
    end
  endtask

  // Plain-mode bytes inside a packed label leave the packed state alone; a plain zero byte ends and clears it.
  task automatic test_mode_switch();
    burst_max  = 3;
    gap_max    = 3;
    stall_mode = 2;
    repeat (3) begin
      write_label_mode(1'b0);
      send_label_byte({6'($urandom_range(1, 47)), 2'($urandom_range(0, 3))}, 1'b1);
      write_label_mode(1'b1);
      repeat ($urandom_range(1, 3)) send_label_byte(8'($urandom_range(1, 255)), 1'b0);
      if ($urandom_range(0, 2) == 0) send_label_byte(8'h00, 1'b0);
      write_label_mode(1'b0);
      repeat (2) send_label_byte(8'($urandom_range(0, 191)), 1'b0);
      send_label_byte(8'hFF, 1'b0);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    n_req       = 0;
    n_res       = 0;
    n_err       = 0;
    idle_cnt    = 0;
    burst_left  = 0;
    burst_max   = 4;
    gap_max     = 2;
    stall_mode  = 0;
    pk_mode     = 1'b0;
    clear_decoder();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_packed();
    test_directed_plain();
    test_random_packed(55);
    test_random_plain(30);
    test_mode_switch();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d label bytes in packed and plain modes, checked %0d results.",
             n_req, n_res);
    if (n_err == 0) begin
      $display("packed_6bit_label_decoder_unit regression: pass");
    end else begin
      $display("packed_6bit_label_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
